### rtl/kpu_pkg.sv
// kpu_pkg: shared types and constants for the k-th permutation unrank unit
// no dependencies

package kpu_pkg;

  localparam int unsigned LenW  = 4;
  localparam int unsigned RankW = 16;
  localparam int unsigned FactW = RankW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_ERR  = 3'b100
  } kpu_state_e;

  // m! saturated to FactW bits, anything above the rank range reads as all ones
  function automatic logic [FactW-1:0] fact_sat(input logic [LenW-1:0] m);
    logic [FactW-1:0] f;
    unique case (m)
      4'd0:    f = FactW'(1);
      4'd1:    f = FactW'(1);
      4'd2:    f = FactW'(2);
      4'd3:    f = FactW'(6);
      4'd4:    f = FactW'(24);
      4'd5:    f = FactW'(120);
      4'd6:    f = FactW'(720);
      4'd7:    f = FactW'(5040);
      4'd8:    f = FactW'(40320);
      default: f = '1;
    endcase
    return f;
  endfunction

endpackage

### rtl/kth_permutation_unrank_unit.sv
// kth_permutation_unrank_unit: k-th lexicographic permutation of 1..n, one element a result
// depends on kpu_pkg
//
//   channel   signals                                               direction
//   in        in_valid_i in_ready_o perm_length_i rank_i             request in
//   out       out_valid_o out_ready_i element_o last_o rank_error_o  result out
//
// one shared subtract-compare unit peels each factorial digit by repeated subtraction:
// each subtraction steps the pool index; once r is below the factorial the element goes out
// a bad length or rank passes through ST_ERR and yields one error result
// in_ready_o is high only while idle; a stalled output register holds the sequencer
// reset clears the sequencer and the output valid, no clearing pass

module kth_permutation_unrank_unit
  import kpu_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [LenW-1:0]  perm_length_i,
  input  logic [RankW-1:0] rank_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LenW-1:0]  element_o,
  output logic             last_o,
  output logic             rank_error_o
);

  localparam int unsigned PoolDepth = (MAX_LENGTH < 15) ? MAX_LENGTH : 15;
  localparam int unsigned IdxW      = (PoolDepth > 1) ? $clog2(PoolDepth) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(PoolDepth);

  kpu_state_e       state_q, state_d;
  logic [RankW-1:0] r_q, r_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [LenW-1:0]  pool_q [PoolDepth];
  logic [LenW-1:0]  pool_d [PoolDepth];

  logic             out_valid_q, out_valid_d;
  logic [LenW-1:0]  element_q, element_d;
  logic             last_q, last_d;
  logic             err_q, err_d;

  logic             in_fire, out_free, bad_req, ge_f, at_end;
  logic [FactW-1:0] f_cur;
  logic [FactW:0]   diff;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign bad_req = (perm_length_i == '0) || (perm_length_i > MaxLen) || (rank_i == '0) ||
                   ({1'b0, rank_i} > fact_sat(perm_length_i));

  // shared subtract-compare against the current factorial
  assign f_cur  = fact_sat(rem_q - LenW'(1));
  assign diff   = {2'b00, r_q} - {1'b0, f_cur};
  assign ge_f   = !diff[FactW];
  assign at_end = (LenW'(idx_q) == rem_q - LenW'(1));

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    pool_d      = pool_q;
    out_valid_d = out_valid_q && !out_ready_i;
    element_d   = element_q;
    last_d      = last_q;
    err_d       = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (bad_req) begin
            state_d = ST_ERR;
          end else begin
            state_d = ST_DIV;
            r_d     = rank_i - RankW'(1);
            rem_d   = perm_length_i;
            idx_d   = '0;
            for (int i = 0; i < PoolDepth; i++) begin
              pool_d[i] = LenW'(i + 1);
            end
          end
        end
      end
      ST_DIV: begin
        if (ge_f && !at_end) begin
          r_d   = diff[RankW-1:0];
          idx_d = idx_q + IdxW'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          element_d   = pool_q[idx_q];
          last_d      = (rem_q == LenW'(1));
          err_d       = 1'b0;
          for (int i = 0; i < PoolDepth - 1; i++) begin
            if (i >= int'(idx_q)) begin
              pool_d[i] = pool_q[i+1];
            end
          end
          rem_d = rem_q - LenW'(1);
          idx_d = '0;
          if (rem_q == LenW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          element_d   = '0;
          last_d      = 1'b1;
          err_d       = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    rem_q     <= rem_d;
    idx_q     <= idx_d;
    pool_q    <= pool_d;
    element_q <= element_d;
    last_q    <= last_d;
    err_q     <= err_d;
  end

  assign out_valid_o  = out_valid_q;
  assign element_o    = element_q;
  assign last_o       = last_q;
  assign rank_error_o = err_q;

  a_div_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q != '0))
    else $error("sequencer working with no positions left");

  a_idx_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (LenW'(idx_q) < rem_q))
    else $error("digit index beyond remaining pool");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (element_q == '0 && last_q))
    else $error("error result not a single zero element");

  a_err_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERR && out_free) |=> (state_q == ST_IDLE && out_valid_q && err_q))
    else $error("error request did not yield its result");

  a_digit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !(ge_f && !at_end) && out_free) |=>
      (out_valid_q && !err_q && element_q != '0))
    else $error("finished digit produced no element");

endmodule
